// ----- hw/rtl/dcq_pkg.sv -----
// shared opcodes, status codes and the control bundle for the command queue
// no dependencies

package dcq_pkg;

   localparam int DCQ_DEPTH = 16;
   localparam int DCQ_TERM_W = 8;
   localparam int DCQ_CMD_W = 16;
   localparam int DCQ_ENTRY_W = DCQ_TERM_W + DCQ_CMD_W;

   localparam logic [2:0] OP_PUSH_BACK = 3'd0;
   localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [2:0] OP_POP_BACK = 3'd2;
   localparam logic [2:0] OP_POP_FRONT = 3'd3;
   localparam logic [2:0] OP_PEEK_BACK = 3'd4;
   localparam logic [2:0] OP_PEEK_FRONT = 3'd5;
   localparam logic [2:0] OP_REMOVE = 3'd6;
   localparam logic [2:0] OP_CLEAR = 3'd7;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic eval;
      logic apply;
      logic [2:0] op;
      logic room;
      logic has;
      logic found;
      logic [DCQ_TERM_W-1:0] term;
      logic [DCQ_CMD_W-1:0] cmd;
   } dcq_ctrl_type;

endpackage

// ----- hw/rtl/dcq_cell.sv -----
// one queue slot: holds an entry, compares it against a key, shifts to neighbors
// depends on dcq_pkg

module dcq_cell import dcq_pkg::*; #(
   parameter int IDX = 0,
   parameter int CNT_W = 5
) (
   input  logic clock,
   input  dcq_ctrl_type ctrl,
   input  logic [CNT_W-1:0] count,
   input  logic [DCQ_TERM_W-1:0] prev_term,
   input  logic [DCQ_CMD_W-1:0] prev_cmd,
   input  logic [DCQ_TERM_W-1:0] next_term,
   input  logic [DCQ_CMD_W-1:0] next_cmd,
   input  logic shift,
   output logic [DCQ_TERM_W-1:0] term,
   output logic [DCQ_CMD_W-1:0] cmd,
   output logic match,
   output logic [DCQ_ENTRY_W-1:0] pick
);

   localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);
   localparam logic [CNT_W-1:0] MyNext = CNT_W'(IDX + 1);

   logic [DCQ_TERM_W-1:0] term_ff, term_in;
   logic [DCQ_CMD_W-1:0] cmd_ff, cmd_in;
   logic match_ff, match_in;
   logic [DCQ_ENTRY_W-1:0] pick_ff, pick_in;
   logic sel;

   always_comb begin
      match_in = match_ff;
      pick_in = pick_ff;
      if (ctrl.op inside {OP_POP_BACK, OP_PEEK_BACK}) begin
         sel = (count == MyNext);
      end else begin
         sel = (MyIdx == '0);
      end
      if (ctrl.eval) begin
         match_in = (MyIdx < count) && (term_ff == ctrl.term) && (cmd_ff == ctrl.cmd);
         pick_in = sel ? {term_ff, cmd_ff} : '0;
      end
   end

   always_comb begin
      term_in = term_ff;
      cmd_in = cmd_ff;
      if (ctrl.apply) begin
         case (ctrl.op)
            OP_PUSH_BACK: begin
               if (ctrl.room && count == MyIdx) begin
                  term_in = ctrl.term;
                  cmd_in = ctrl.cmd;
               end
            end
            OP_PUSH_FRONT: begin
               if (ctrl.room) begin
                  term_in = prev_term;
                  cmd_in = prev_cmd;
               end
            end
            OP_POP_FRONT: begin
               if (ctrl.has) begin
                  term_in = next_term;
                  cmd_in = next_cmd;
               end
            end
            OP_REMOVE: begin
               if (ctrl.found && shift) begin
                  term_in = next_term;
                  cmd_in = next_cmd;
               end
            end
            default: begin
               term_in = term_ff;
               cmd_in = cmd_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
      cmd_ff <= cmd_in;
      match_ff <= match_in;
      pick_ff <= pick_in;
   end

   assign term = term_ff;
   assign cmd = cmd_ff;
   assign match = match_ff;
   assign pick = pick_ff;

endmodule

// ----- hw/rtl/dcq_scan.sv -----
// reduction over the cell row: prefix or of match flags and or tree of picked entries
// depends on dcq_pkg

module dcq_scan import dcq_pkg::*; #(
   parameter int N = 16
) (
   input  logic [N-1:0] match,
   input  logic [N-1:0][DCQ_ENTRY_W-1:0] pick,
   output logic [N-1:0] shift,
   output logic found,
   output logic [DCQ_ENTRY_W-1:0] pick_or
);

   localparam int Levels = $clog2(N);
   localparam int Np = 1 << Levels;

   logic [Levels:0][N-1:0] pre;
   logic [2*Np-2:0][DCQ_ENTRY_W-1:0] node;

   assign pre[0] = match;

   for (genvar l = 1; l <= Levels; l++) begin : g_lvl
      for (genvar i = 0; i < N; i++) begin : g_bit
         if (i >= (1 << (l - 1))) begin : g_or
            assign pre[l][i] = pre[l-1][i] | pre[l-1][i - (1 << (l - 1))];
         end else begin : g_pass
            assign pre[l][i] = pre[l-1][i];
         end
      end
   end

   for (genvar i = 0; i < Np; i++) begin : g_leaf
      if (i < N) begin : g_used
         assign node[Np-1+i] = pick[i];
      end else begin : g_pad
         assign node[Np-1+i] = '0;
      end
   end

   for (genvar k = 0; k < Np - 1; k++) begin : g_node
      assign node[k] = node[2*k+1] | node[2*k+2];
   end

   assign shift = pre[Levels];
   assign found = pre[Levels][N-1];
   assign pick_or = node[0];

endmodule

// ----- hw/rtl/double_ended_command_queue_unit.sv -----
// double-ended command queue with remove by key, built as a row of shifting cells
// depends on dcq_pkg, dcq_cell, dcq_scan
//
// usage:
//   req channel: req_tuser carries the operation (push/pop/peek at either end,
//   remove by key, clear), req_tdata the terminal id and command id
//   rsp channel: rsp_tuser carries the status (ok, empty, full, not_found),
//   rsp_tdata the entry popped or peeked (zero otherwise) and the fill level
//   every request transfer gives exactly one response transfer, in order
//   timing: a request goes through an evaluate state and then an apply state; in
//   evaluate each cell compares its entry with the key and selects itself if it
//   sits at the requested end, in apply the row reduction resolves the first
//   match and the cells shift; the response register is loaded when apply ends;
//   the next request is taken during apply, so successive requests overlap
//   reset: the queue is empty and the response valid flag is cleared; slot
//   contents are left as they are and are only read below the fill level
//   stall: a finished response waits in the output register; while it is not
//   taken, a following request is accepted and held in its apply state

module double_ended_command_queue_unit import dcq_pkg::*; #(
   parameter int QUEUE_DEPTH = DCQ_DEPTH,
   localparam int CntW = $clog2(QUEUE_DEPTH + 1),
   localparam int RspW = ((DCQ_ENTRY_W + CntW + 7) / 8) * 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [23:0] req_tdata,     // terminal_id, command_id
   input  logic [2:0] req_tuser,      // req_type
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [RspW-1:0] rsp_tdata, // out_terminal, out_command, fill_level
   output logic [1:0] rsp_tuser       // status
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;
   localparam logic [CntW-1:0] Full = CntW'(QUEUE_DEPTH);

   logic [1:0] state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic [DCQ_TERM_W-1:0] term_ff, term_in;
   logic [DCQ_CMD_W-1:0] cmd_ff, cmd_in;
   logic [CntW-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] status_ff, status_in;
   logic [DCQ_ENTRY_W-1:0] entry_ff, entry_in;
   logic [CntW-1:0] fill_ff;

   logic req_fire, can_apply, room, has, found;
   dcq_ctrl_type ctrl;

   logic [QUEUE_DEPTH-1:0][DCQ_TERM_W-1:0] cell_term;
   logic [QUEUE_DEPTH-1:0][DCQ_CMD_W-1:0] cell_cmd;
   logic [QUEUE_DEPTH-1:0] cell_match;
   logic [QUEUE_DEPTH-1:0] cell_shift;
   logic [QUEUE_DEPTH-1:0][DCQ_ENTRY_W-1:0] cell_pick;
   logic [DCQ_ENTRY_W-1:0] pick_or;

   assign can_apply = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == S_IDLE) || can_apply;
   assign req_fire = req_tvalid && req_tready;
   assign room = (count_ff != Full);
   assign has = (count_ff != '0);

   assign ctrl.eval = (state_ff == S_EVAL);
   assign ctrl.apply = can_apply;
   assign ctrl.op = op_ff;
   assign ctrl.room = room;
   assign ctrl.has = has;
   assign ctrl.found = found;
   assign ctrl.term = term_ff;
   assign ctrl.cmd = cmd_ff;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [DCQ_TERM_W-1:0] p_term, n_term;
      logic [DCQ_CMD_W-1:0] p_cmd, n_cmd;
      if (i == 0) begin : g_head
         assign p_term = term_ff;
         assign p_cmd = cmd_ff;
      end else begin : g_mid
         assign p_term = cell_term[i-1];
         assign p_cmd = cell_cmd[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign n_term = '0;
         assign n_cmd = '0;
      end else begin : g_body
         assign n_term = cell_term[i+1];
         assign n_cmd = cell_cmd[i+1];
      end
      dcq_cell #(
         .IDX(i),
         .CNT_W(CntW)
      ) u_cell (
         .clock(clock),
         .ctrl(ctrl),
         .count(count_ff),
         .prev_term(p_term),
         .prev_cmd(p_cmd),
         .next_term(n_term),
         .next_cmd(n_cmd),
         .shift(cell_shift[i]),
         .term(cell_term[i]),
         .cmd(cell_cmd[i]),
         .match(cell_match[i]),
         .pick(cell_pick[i])
      );
   end

   dcq_scan #(
      .N(QUEUE_DEPTH)
   ) u_scan (
      .match(cell_match),
      .pick(cell_pick),
      .shift(cell_shift),
      .found(found),
      .pick_or(pick_or)
   );

   always_comb begin
      state_in = state_ff;
      if (req_fire) begin
         state_in = S_EVAL;
      end else if (state_ff == S_EVAL) begin
         state_in = S_APPLY;
      end else if (can_apply) begin
         state_in = S_IDLE;
      end
   end

   always_comb begin
      op_in = op_ff;
      term_in = term_ff;
      cmd_in = cmd_ff;
      if (req_fire) begin
         op_in = req_tuser;
         term_in = req_tdata[7:0];
         cmd_in = req_tdata[23:8];
      end
   end

   always_comb begin
      status_in = ST_OK;
      entry_in = '0;
      count_in = count_ff;
      case (op_ff)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (room) begin
               count_in = count_ff + 1'b1;
            end else begin
               status_in = ST_FULL;
            end
         end
         OP_POP_BACK, OP_POP_FRONT: begin
            if (has) begin
               entry_in = pick_or;
               count_in = count_ff - 1'b1;
            end else begin
               status_in = ST_EMPTY;
            end
         end
         OP_PEEK_BACK, OP_PEEK_FRONT: begin
            if (has) begin
               entry_in = pick_or;
            end else begin
               status_in = ST_EMPTY;
            end
         end
         OP_REMOVE: begin
            if (found) begin
               count_in = count_ff - 1'b1;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (can_apply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (can_apply) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      term_ff <= term_in;
      cmd_ff <= cmd_in;
      if (can_apply) begin
         status_ff <= status_in;
         entry_ff <= entry_in;
         fill_ff <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = status_ff;
   assign rsp_tdata = RspW'({fill_ff, entry_ff[DCQ_CMD_W-1:0],
                             entry_ff[DCQ_ENTRY_W-1:DCQ_CMD_W]});

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Full)
      else $error("fill level beyond depth");

   a_eval_then_apply: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EVAL |=> state_ff == S_APPLY)
      else $error("evaluation not followed by apply");

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_EVAL)
      else $error("accepted request did not start evaluation");

   a_miss_keeps_count: assert property (@(posedge clock) disable iff (reset)
      can_apply && op_ff == OP_REMOVE && !found |=> count_ff == $past(count_ff))
      else $error("failed remove changed fill level");

   a_full_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_FULL |-> fill_ff == Full)
      else $error("full status with queue not full");

endmodule

// ----- verif/tb_double_ended_command_queue_unit.sv -----
// testbench for double_ended_command_queue_unit: drives request transfers in bursts,
// stalls the response side, and checks every response against a queue-based predictor
// depends on dcq_pkg and double_ended_command_queue_unit

module tb_double_ended_command_queue_unit import dcq_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CNT_W = $clog2(DCQ_DEPTH + 1);
   localparam int RSP_W = ((DCQ_ENTRY_W + CNT_W + 7) / 8) * 8;
   localparam int ITEM_COUNT = 1350;
   localparam int STALL_LIMIT = 3000;
   localparam int LONG_HOLD = 400;
   localparam int PRINT_CAP = 100;

   typedef struct packed {
      logic [DCQ_TERM_W-1:0] term;
      logic [DCQ_CMD_W-1:0] cmd;
   } entry_type;

   typedef struct packed {
      logic [1:0] status;
      entry_type ent;
      logic [CNT_W-1:0] fill;
   } outcome_type;

   typedef struct packed {
      logic [2:0] op;
      entry_type ent;
   } request_type;

   class command_queue_tracker;
      entry_type held[$];
      outcome_type due[$];
      int errors = 0;
      int checked = 0;
      int op_seen[8];
      int status_seen[4];

      function void take_request(request_type r);
         outcome_type o;
         int idx;
         o = '0;
         o.status = ST_OK;
         idx = -1;
         op_seen[r.op]++;
         case (r.op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
               if (held.size() >= DCQ_DEPTH) o.status = ST_FULL;
               else if (r.op == OP_PUSH_BACK) held.push_back(r.ent);
               else held.push_front(r.ent);
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
               if (held.size() == 0) begin
                  o.status = ST_EMPTY;
               end else begin
                  o.ent = held[held.size() - 1];
                  if (r.op == OP_POP_BACK) void'(held.pop_back());
               end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
               if (held.size() == 0) begin
                  o.status = ST_EMPTY;
               end else begin
                  o.ent = held[0];
                  if (r.op == OP_POP_FRONT) void'(held.pop_front());
               end
            end
            OP_REMOVE: begin
               o.status = ST_NOT_FOUND;
               foreach (held[i]) if (idx < 0 && held[i] == r.ent) idx = i;
               if (idx >= 0) begin
                  held.delete(idx);
                  o.status = ST_OK;
               end
            end
            default: begin
               held.delete();
            end
         endcase
         o.fill = CNT_W'(held.size());
         due.push_back(o);
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= PRINT_CAP) $display("mismatch at response %0d: %s", checked, msg);
      endtask

      task match_response(logic [1:0] status, logic [DCQ_TERM_W-1:0] term,
                          logic [DCQ_CMD_W-1:0] cmd, logic [CNT_W-1:0] fill);
         outcome_type o;
         if (due.size() == 0) begin
            report_mismatch("response transfer with nothing outstanding");
         end else begin
            o = due.pop_front();
            if (status !== o.status)
               report_mismatch($sformatf("status %0d, want %0d", status, o.status));
            if (term !== o.ent.term)
               report_mismatch($sformatf("terminal 0x%0h, want 0x%0h", term, o.ent.term));
            if (cmd !== o.ent.cmd)
               report_mismatch($sformatf("command 0x%0h, want 0x%0h", cmd, o.ent.cmd));
            if (fill !== o.fill)
               report_mismatch($sformatf("fill %0d, want %0d", fill, o.fill));
         end
         status_seen[status]++;
         checked++;
      endtask
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;     // terminal_id, command_id
   logic [2:0] req_tuser = '0;      // req_type
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;     // out_terminal, out_command, fill_level
   logic [1:0] rsp_tuser;           // status

   command_queue_tracker tracker = new();
   bit hold_rsp = 1'b0;
   int sent = 0;
   int burst_left = 0;
   int quiet_cycles = 0;

   double_ended_command_queue_unit dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.match_response(rsp_tuser, rsp_tdata[7:0], rsp_tdata[23:8],
                                rsp_tdata[24 +: CNT_W]);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // response side stall pattern, with a long hold when asked
   initial begin
      int mode;
      int span;
      int phase;
      while (reset) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 200);
         for (phase = 0; phase < span; phase++) begin
            if (hold_rsp) begin
               rsp_tready <= 1'b0;
               repeat (LONG_HOLD) @(posedge clock);
               hold_rsp = 1'b0;
            end else begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= 1'($urandom_range(0, 1));
                  2: rsp_tready <= (phase % 3 != 0);
                  default: rsp_tready <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   function automatic request_type make_req(logic [2:0] op, logic [7:0] term,
                                            logic [15:0] cmd);
      request_type r;
      r.op = op;
      r.ent.term = term;
      r.ent.cmd = cmd;
      return r;
   endfunction

   function automatic entry_type random_entry();
      entry_type e;
      case ($urandom_range(0, 3))
         0, 1: begin
            e.term = 8'($urandom_range(0, 255));
            e.cmd = 16'($urandom_range(0, 65535));
         end
         2: begin
            e.term = 8'($urandom_range(0, 3));
            e.cmd = 16'($urandom_range(0, 3));
         end
         default: begin
            e.term = $urandom_range(0, 1) ? 8'hff : 8'h00;
            e.cmd = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
         end
      endcase
      return e;
   endfunction

   // remove key: mostly one that is held, otherwise a random one
   function automatic entry_type remove_key();
      if (tracker.held.size() != 0 && $urandom_range(0, 9) < 7)
         return tracker.held[$urandom_range(0, tracker.held.size() - 1)];
      return random_entry();
   endfunction

   task automatic send_request(request_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 24);
         case ($urandom_range(0, 3))
            0: gap = 0;
            1, 2: gap = $urandom_range(1, 4);
            default: gap = $urandom_range(5, 20);
         endcase
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= r.op;
      req_tdata <= {r.ent.cmd, r.ent.term};
      do @(posedge clock); while (!req_tready);
      tracker.take_request(r);
      sent++;
   endtask

   task automatic drain_outstanding();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.due.size() != 0);
   endtask

   task automatic send_mixed(int count);
      int pick;
      entry_type e;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            e = random_entry();
            send_request(make_req($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                                  e.term, e.cmd));
         end else if (pick < 50) begin
            send_request(make_req($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, '0, '0));
         end else if (pick < 62) begin
            e = random_entry();
            send_request(make_req($urandom_range(0, 1) ? OP_PEEK_BACK : OP_PEEK_FRONT,
                                  e.term, e.cmd));
         end else if (pick < 96) begin
            e = remove_key();
            send_request(make_req(OP_REMOVE, e.term, e.cmd));
         end else begin
            e = random_entry();
            send_request(make_req(OP_CLEAR, e.term, e.cmd));
         end
      end
   endtask

   task automatic fill_up();
      entry_type e;
      while (tracker.held.size() < DCQ_DEPTH) begin
         e = random_entry();
         send_request(make_req($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                               e.term, e.cmd));
         if ($urandom_range(0, 5) == 0)
            send_request(make_req($urandom_range(0, 1) ? OP_PEEK_BACK : OP_PEEK_FRONT, '0, '0));
      end
      repeat ($urandom_range(1, 3)) begin
         e = random_entry();
         send_request(make_req($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                               e.term, e.cmd));
      end
   endtask

   task automatic drain_down();
      int extra;
      extra = $urandom_range(1, 2);
      while (tracker.held.size() != 0 || extra > 0) begin
         if (tracker.held.size() == 0) extra--;
         case ($urandom_range(0, 4))
            0: send_request(make_req(OP_PEEK_FRONT, '0, '0));
            1: send_request(make_req(OP_POP_BACK, '0, '0));
            default: send_request(make_req(OP_POP_FRONT, '0, '0));
         endcase
      end
   endtask

   task automatic remove_sweep();
      entry_type e;
      repeat (tracker.held.size() + 1) begin
         e = remove_key();
         send_request(make_req(OP_REMOVE, e.term, e.cmd));
      end
   endtask

   initial begin
      bit held_off;
      bit paused;
      held_off = 1'b0;
      paused = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty queue corner cases
      send_request(make_req(OP_POP_BACK, '0, '0));
      send_request(make_req(OP_POP_FRONT, '0, '0));
      send_request(make_req(OP_PEEK_BACK, 8'hff, 16'hffff));
      send_request(make_req(OP_PEEK_FRONT, '0, '0));
      send_request(make_req(OP_REMOVE, 8'h12, 16'h3456));
      send_request(make_req(OP_CLEAR, '0, '0));
      // field extremes, both ends, middle removal, miss, sole pop
      send_request(make_req(OP_PUSH_BACK, 8'h00, 16'h0000));
      send_request(make_req(OP_PUSH_BACK, 8'hff, 16'hffff));
      send_request(make_req(OP_PUSH_FRONT, 8'ha5, 16'h5a5a));
      send_request(make_req(OP_PEEK_FRONT, '0, '0));
      send_request(make_req(OP_PEEK_BACK, '0, '0));
      send_request(make_req(OP_REMOVE, 8'h00, 16'h0000));
      send_request(make_req(OP_REMOVE, 8'hff, 16'h0000));
      send_request(make_req(OP_POP_FRONT, '0, '0));
      send_request(make_req(OP_POP_BACK, '0, '0));
      send_request(make_req(OP_PEEK_BACK, '0, '0));
      // sole entry removal, clear with entries held
      send_request(make_req(OP_PUSH_FRONT, 8'h5a, 16'ha5a5));
      send_request(make_req(OP_REMOVE, 8'h5a, 16'ha5a5));
      send_request(make_req(OP_PUSH_BACK, 8'h01, 16'h0001));
      send_request(make_req(OP_PUSH_BACK, 8'h02, 16'h0002));
      send_request(make_req(OP_CLEAR, 8'h55, 16'haaaa));
      send_request(make_req(OP_PEEK_FRONT, '0, '0));

      fill_up();
      while (sent < ITEM_COUNT) begin
         if (!held_off && sent > 500) begin
            held_off = 1'b1;
            hold_rsp = 1'b1;
            send_mixed(40);
         end else if (!paused && sent > 900) begin
            paused = 1'b1;
            drain_outstanding();
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: send_mixed($urandom_range(10, 40));
            4, 5: fill_up();
            6, 7: drain_down();
            default: remove_sweep();
         endcase
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.due.size() != 0);
      repeat (8) @(posedge clock);

      $display("%0d requests: %0d pushes, %0d pops, %0d peeks, %0d removes, %0d clears",
               sent, tracker.op_seen[OP_PUSH_BACK] + tracker.op_seen[OP_PUSH_FRONT],
               tracker.op_seen[OP_POP_BACK] + tracker.op_seen[OP_POP_FRONT],
               tracker.op_seen[OP_PEEK_BACK] + tracker.op_seen[OP_PEEK_FRONT],
               tracker.op_seen[OP_REMOVE], tracker.op_seen[OP_CLEAR]);
      $display("%0d responses checked: ok %0d, empty %0d, full %0d, not found %0d",
               tracker.checked, tracker.status_seen[ST_OK], tracker.status_seen[ST_EMPTY],
               tracker.status_seen[ST_FULL], tracker.status_seen[ST_NOT_FOUND]);
      if (tracker.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/dcq_pkg.sv
hw/rtl/dcq_cell.sv
hw/rtl/dcq_scan.sv
hw/rtl/double_ended_command_queue_unit.sv
verif/tb_double_ended_command_queue_unit.sv
